// ===== rtl/core/qre_pkg.sv =====
// qre_pkg: shared types, constants and helpers of the quantizing RLE encoder.
// No dependencies; imported by qre_ctrl, qre_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package qre_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 3;
   localparam int unsigned DIV_STEPS   = BYTE_W;
   localparam int unsigned STEP_CNT_W  = $clog2(DIV_STEPS);
   localparam logic [BYTE_W-1:0] QUANT_RESET = 8'd16;
   localparam logic [BYTE_W-1:0] BYTE_ONES   = 8'hFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_UPDATE
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture an input beat, start the divide
      logic step;     // one restoring-divide iteration
      logic update;   // run update, push code bytes
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_empty;
   } dp_status_type;

   // Count-field width 8-S, S = bit length of floor(255/Q).
   // bitlen(255/Q) > k  <=>  Q <= (255 >> k).
   function automatic logic [LEN_W-1:0] count_bits(input logic [BYTE_W-1:0] quant);
      logic [3:0] s;
      s = 4'd0;
      for (int k = 0; k < BYTE_W; k++) begin
         if (quant <= (BYTE_ONES >> k)) begin
            s = s + 4'd1;
         end
      end
      return LEN_W'(4'd8 - s);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qre_ctrl.sv =====
// qre_ctrl: sequencer for accept / divide / run update.
// Depends on qre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qre_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  qre_pkg::dp_status_type      status,
   output qre_pkg::dp_cmd_type         cmd
);
   import qre_pkg::*;

   ctrl_state_type          state_ff, state_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      in_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + STEP_CNT_W'(1);
            if (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // wait for the previous item's code bytes to drain
            if (status.out_empty) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/qre_dp.sv =====
// qre_dp: divisor register, restoring divider, run state and 2-entry output queue.
// Depends on qre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qre_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [qre_pkg::BYTE_W-1:0]  csr_wr_data,
   input  wire logic [qre_pkg::BYTE_W-1:0]  in_byte,
   input  wire logic                        in_last,
   input  qre_pkg::dp_cmd_type              cmd,
   output qre_pkg::dp_status_type           status,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [qre_pkg::BYTE_W-1:0]       out_code,
   output logic                             out_last
);
   import qre_pkg::*;

   logic [BYTE_W-1:0] quant_ff;

   // divider
   logic [BYTE_W-1:0] quo_ff, rem_ff;
   logic              last_ff;
   logic [BYTE_W:0]   rem_trial;
   logic              rem_ge;

   // run state
   logic [BYTE_W-1:0] run_value_ff, run_value_in;
   logic [LEN_W-1:0]  run_len_ff, run_len_in;
   logic              run_open_ff, run_open_in;

   // output queue
   logic [BYTE_W-1:0] slot0_code_ff, slot1_code_ff;
   logic              slot0_last_ff, slot1_last_ff;
   logic [1:0]        count_ff;

   logic [LEN_W-1:0]  cb;
   logic [LEN_W-1:0]  cap;
   logic [BYTE_W-1:0] cmask;
   logic              merge, emit_close;
   logic [BYTE_W-1:0] close_code, final_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         quant_ff <= QUANT_RESET;
      end else if (csr_wr_en) begin
         quant_ff <= (csr_wr_data == '0) ? BYTE_W'(1) : csr_wr_data;
      end
   end

   assign rem_trial = {rem_ff, quo_ff[BYTE_W-1]};
   assign rem_ge    = (rem_trial >= {1'b0, quant_ff});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quo_ff  <= in_byte;
         rem_ff  <= '0;
         last_ff <= in_last;
      end else if (cmd.step) begin
         rem_ff <= rem_ge ? BYTE_W'(rem_trial - {1'b0, quant_ff}) : rem_trial[BYTE_W-1:0];
         quo_ff <= {quo_ff[BYTE_W-2:0], rem_ge};
      end
   end

   // packing layout from the current divisor
   assign cb    = count_bits(quant_ff);
   assign cap   = (cb == '0) ? LEN_W'(1) : cb;
   assign cmask = BYTE_W'((9'd1 << cb) - 9'd1);

   assign merge      = run_open_ff && (run_value_ff == quo_ff) && (run_len_ff < cap);
   assign emit_close = run_open_ff && !merge;

   always_comb begin
      run_value_in = merge ? run_value_ff : quo_ff;
      run_len_in   = merge ? LEN_W'(run_len_ff + LEN_W'(1)) : LEN_W'(1);
      run_open_in  = 1'b1;
   end

   assign close_code = BYTE_W'(run_value_ff << cb) | (BYTE_W'(run_len_ff) & cmask);
   assign final_code = BYTE_W'(run_value_in << cb) | (BYTE_W'(run_len_in) & cmask);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff <= '0;
         run_len_ff   <= '0;
         run_open_ff  <= 1'b0;
      end else if (cmd.update) begin
         if (last_ff) begin
            run_value_ff <= '0;
            run_len_ff   <= '0;
            run_open_ff  <= 1'b0;
         end else begin
            run_value_ff <= run_value_in;
            run_len_ff   <= run_len_in;
            run_open_ff  <= run_open_in;
         end
      end
   end

   // queue: push only when empty, so push and pop never meet
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         priority if (cmd.update) begin
            count_ff <= 2'(emit_close) + 2'(last_ff);
         end else if (out_ready && (count_ff != '0)) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.update) begin
         slot0_code_ff <= emit_close ? close_code : final_code;
         slot0_last_ff <= !emit_close;
         slot1_code_ff <= final_code;
         slot1_last_ff <= 1'b1;
      end else if (out_ready && (count_ff != '0)) begin
         slot0_code_ff <= slot1_code_ff;
         slot0_last_ff <= slot1_last_ff;
      end
   end

   assign status.out_empty = (count_ff == '0);
   assign out_valid        = (count_ff != '0);
   assign out_code         = slot0_code_ff;
   assign out_last         = slot0_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/quantizing_rle_encoder.sv =====
// A byte accepted on req_* goes through 8 restoring-divide iterations, the run update
//   (which waits for an empty queue) and one queue register on its way to rsp_*.
// A new input byte is taken only in idle, once the previous byte is through the
//   bit-serial divider by Q and its run update.
// Reset: synchronous, active high; divisor returns to 16, no run open, queue empty.
// Depends on qre_pkg, qre_ctrl, qre_dp.
`timescale 1ns / 1ps
`default_nettype none

module quantizing_rle_encoder (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // input stream
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [qre_pkg::BYTE_W-1:0]  req_tdata,   // [7:0] in_byte
   input  wire logic                        req_tlast,   // in_last
   // code-byte stream
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [qre_pkg::BYTE_W-1:0]       rsp_tdata,   // [7:0] code_byte
   output logic                             rsp_tlast,   // out_last
   // divisor register
   input  wire logic                        csr_wr_en,
   input  wire logic [qre_pkg::BYTE_W-1:0]  csr_wr_data  // [7:0] quant_divisor
);
   import qre_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Controller: idle -> 8 divide steps -> update (waits for an empty queue).
   qre_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   // Datapath: quotient feeds the run compare; a closed run and the flushed
   // final run can both land in the 2-entry queue in the same update cycle.
   qre_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_byte     (req_tdata),
      .in_last     (req_tlast),
      .cmd         (cmd),
      .status      (status),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_code    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/core/qre_checker.sv =====
// qre_checker: port-level checks on quantizing_rle_encoder, attached by bind.
// Depends on qre_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module qre_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   input  wire logic                        req_tready,
   input  wire logic [qre_pkg::BYTE_W-1:0]  req_tdata,
   input  wire logic                        req_tlast,
   input  wire logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  wire logic [qre_pkg::BYTE_W-1:0]  rsp_tdata,
   input  wire logic                        rsp_tlast,
   input  wire logic                        csr_wr_en,
   input  wire logic [qre_pkg::BYTE_W-1:0]  csr_wr_data
);
   import qre_pkg::*;

   logic req_beat;
   assign req_beat = req_tvalid && req_tready;

   // stalled code beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // nothing to send right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // divider busy: no new beat for the divide and update cycles
   a_busy_1: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_tready)
      else $error("req accepted during divide");

   a_busy_9: assert property (@(posedge clock) disable iff (reset)
      req_beat |-> ##9 !req_tready)
      else $error("req accepted before run update");

   // a config write while a divide is in flight is outside use
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |-> req_tready || ($past(req_beat) == 1'b0 && req_tready))
      else $error("divisor written while busy");

endmodule

bind quantizing_rle_encoder qre_checker u_qre_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .req_tdata   (req_tdata),
   .req_tlast   (req_tlast),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tlast   (rsp_tlast),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);

`default_nettype wire

// ===== dv/qre_run_checker.sv =====
// qre_run_checker: watches the byte and code-byte streams of the quantizing RLE encoder,
// predicts every code byte and compares. Depends on qre_pkg; instantiated by the tb top.
`timescale 1ns / 1ps

module qre_run_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [qre_pkg::BYTE_W-1:0] req_tdata,
   input  logic                       req_tlast,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [qre_pkg::BYTE_W-1:0] rsp_tdata,
   input  logic                       rsp_tlast,
   input  logic                       csr_wr_en,
   input  logic [qre_pkg::BYTE_W-1:0] csr_wr_data,
   output int unsigned                mismatches,
   output int unsigned                n_pending,
   output int unsigned                n_checked
);
   import qre_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] code;
      logic              last;
   } code_beat_type;

   code_beat_type     expected_codes[$];
   logic [BYTE_W-1:0] divisor  = QUANT_RESET;
   logic [BYTE_W-1:0] run_val  = '0;
   logic [LEN_W-1:0]  run_len  = '0;
   logic              run_open = 1'b0;
   int unsigned       err_cnt  = 0;
   int unsigned       chk_cnt  = 0;

   // bit length of 255/Q: width of the value field
   function automatic logic [3:0] value_bits(input logic [BYTE_W-1:0] div);
      logic [BYTE_W-1:0] span;
      logic [3:0]        s;
      span = BYTE_ONES / div;
      s = 4'd0;
      for (int k = 0; k < BYTE_W; k++) begin
         if (span[k]) begin
            s = 4'(k + 1);
         end
      end
      return s;
   endfunction

   function automatic logic [BYTE_W-1:0] pack_code(input logic [BYTE_W-1:0] value,
                                                   input logic [LEN_W-1:0]  count,
                                                   input logic [3:0]        s);
      logic [3:0]        cb;
      logic [BYTE_W-1:0] cmask;
      cb = 4'd8 - s;
      cmask = 8'((9'd1 << cb) - 9'd1);
      return ((value << cb) & ~cmask) | ({5'd0, count} & cmask);
   endfunction

   task automatic encode_byte(input logic [BYTE_W-1:0] in_byte, input logic in_last);
      logic [BYTE_W-1:0] q;
      logic [3:0]        s;
      logic [LEN_W-1:0]  cap;
      q = in_byte / divisor;
      s = value_bits(divisor);
      cap = (s < 4'd8) ? 3'(4'd8 - s) : 3'd1;
      if (run_open && run_val == q && run_len < cap) begin
         run_len = run_len + 3'd1;
      end else begin
         if (run_open) begin
            expected_codes.push_back(
               code_beat_type'{code: pack_code(run_val, run_len, s), last: 1'b0});
         end
         run_val = q;
         run_len = 3'd1;
         run_open = 1'b1;
      end
      if (in_last) begin
         expected_codes.push_back(
            code_beat_type'{code: pack_code(run_val, run_len, s), last: 1'b1});
         run_val = '0;
         run_len = '0;
         run_open = 1'b0;
      end
   endtask

   task automatic check_code(input logic [BYTE_W-1:0] code, input logic last);
      code_beat_type want;
      if (expected_codes.size() == 0) begin
         err_cnt++;
         if (err_cnt <= 10) begin
            $display("[%0t] unexpected code beat %02h last %0b", $realtime, code, last);
         end
      end else begin
         want = expected_codes.pop_front();
         chk_cnt++;
         if (want.code !== code || want.last !== last) begin
            err_cnt++;
            if (err_cnt <= 10) begin
               $display("[%0t] code beat %0d: expected %02h last %0b, got %02h last %0b",
                        $realtime, chk_cnt, want.code, want.last, code, last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_codes.delete();
         divisor = QUANT_RESET;
         run_val = '0;
         run_len = '0;
         run_open = 1'b0;
      end else begin
         // results first: nothing accepted now can come out at this same edge
         if (rsp_tvalid && rsp_tready) begin
            check_code(rsp_tdata, rsp_tlast);
         end
         if (csr_wr_en) begin
            divisor = (csr_wr_data == '0) ? 8'd1 : csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            encode_byte(req_tdata, req_tlast);
         end
      end
      n_pending  <= expected_codes.size();
      mismatches <= err_cnt;
      n_checked  <= chk_cnt;
   end

endmodule

// ===== dv/tb_quantizing_rle_encoder.sv =====
// tb_quantizing_rle_encoder: stimulus and verdict for the quantizing RLE encoder.
// Depends on qre_pkg, the encoder RTL and qre_run_checker (dv/qre_run_checker.sv).
`timescale 1ns / 1ps

module tb_quantizing_rle_encoder;
   import qre_pkg::*;

   localparam int unsigned GAP_PCT       = 18;  // idle beats per hundred, each side
   localparam int unsigned SETTLE_CYCLES = 24;  // > divide + update latency of one byte
   localparam int unsigned TAIL_CYCLES   = 30;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata   = '0;
   logic              req_tlast   = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [BYTE_W-1:0] rsp_tdata;
   logic              rsp_tlast;
   logic              csr_wr_en   = 1'b0;
   logic [BYTE_W-1:0] csr_wr_data = '0;

   int unsigned mismatches;
   int unsigned n_pending;
   int unsigned n_checked;

   bit                quiet       = 1'b0;  // no idling on either side while set
   logic [BYTE_W-1:0] cur_div     = QUANT_RESET;  // only shapes stimulus
   int unsigned       bytes_sent  = 0;
   int unsigned       blocks_sent = 0;
   int unsigned       div_writes  = 0;

   always #2 clock = ~clock;

   quantizing_rle_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   qre_run_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .n_pending   (n_pending),
      .n_checked   (n_checked)
   );

   // result side backpressure
   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= GAP_PCT);
      end
   end

   // one input beat, with random idle beats ahead of it
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      while (!quiet && $urandom_range(99) < GAP_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (last) begin
         blocks_sent++;
      end
   endtask

   // stop sending and wait for every predicted code beat
   // (first edge lets the checker's count catch up with the last accepted beat)
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (n_pending != 0) begin
         @(posedge clock);
      end
   endtask

   // divisor writes only with the encoder idle; a byte with no code out
   // may still be in the divider, so settle past its latency first
   task automatic write_divisor(input logic [BYTE_W-1:0] d);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= d;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_div = (d == '0) ? 8'd1 : d;
      div_writes++;
   endtask

   // blocks of random length, mostly runs of bytes in one quantization bucket;
   // leave_open sends the last block without req_tlast so its run crosses the next divisor write
   task automatic run_blocks(input int unsigned budget, input bit leave_open);
      int unsigned       sent;
      int unsigned       blen;
      int unsigned       q;
      int unsigned       lo;
      int unsigned       hi;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] prev;
      sent = 0;
      prev = 8'($urandom);
      while (sent < budget) begin
         blen = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         for (int i = 0; i < blen && sent < budget; i++) begin
            if ($urandom_range(99) < 65) begin
               q  = prev / cur_div;
               lo = q * cur_div;
               hi = lo + cur_div - 1;
               if (hi > 255) begin
                  hi = 255;
               end
               b = 8'($urandom_range(hi, lo));
            end else begin
               b = 8'($urandom);
            end
            sent++;
            send_byte(b, (i == blen - 1) || (sent == budget && !leave_open));
            prev = b;
         end
      end
   endtask

   initial begin
      logic [BYTE_W-1:0] div_plan[9];
      div_plan = '{8'd0, 8'd255, 8'd3, 8'd128, 8'd127, 8'd1,
                   8'($urandom_range(255, 1)), QUANT_RESET, 8'($urandom_range(64, 2))};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, reset divisor 16: 4 value bits, runs capped at 4
      send_byte(8'h00, 1'b1);                  // single-byte block
      repeat (8) send_byte(8'hFF, 1'b0);       // two full runs at the cap
      send_byte(8'hFF, 1'b1);                  // leftover run of one, flushed
      send_byte(8'h10, 1'b0);
      send_byte(8'h1F, 1'b0);
      send_byte(8'h20, 1'b1);                  // final byte opens its own run

      // divisor one: bare values, every byte its own code
      write_divisor(8'd1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);

      // divisor 255: one value bit, cap 7; leave a run of five zeros open
      write_divisor(8'd255);
      send_byte(8'h00, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h1F, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(8'hFE, 1'b0);

      // cap drops to 5 under the open run: next equal byte closes it
      write_divisor(8'd32);
      send_byte(8'h00, 1'b0);

      // divisor 2 mid-block: cap 1, stored run repacked in the new layout
      write_divisor(8'd2);
      send_byte(8'h01, 1'b0);
      send_byte(8'hFF, 1'b1);

      // --- random phases over a spread of divisors
      foreach (div_plan[p]) begin
         write_divisor(div_plan[p]);
         quiet = (p == 4);
         if (p == 2) begin
            run_blocks(30, 1'b1);
            wait_drained();                    // sender holds until all codes are out
            run_blocks(28, p[0]);
         end else begin
            run_blocks(58, p[0]);
         end
      end
      quiet = 1'b0;

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run: %0d bytes in %0d closed blocks, %0d divisor writes, %0d code beats checked",
               bytes_sent, blocks_sent, div_writes, n_checked);
      $display("covered divisors 0..255 extremes, capped runs, mid-block divisor changes");
      if (mismatches == 0 && n_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d code beats never seen", mismatches, n_pending);
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("timeout: %0d code beats still expected", n_pending);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/qre_pkg.sv
rtl/core/qre_ctrl.sv
rtl/core/qre_dp.sv
rtl/core/quantizing_rle_encoder.sv
rtl/core/qre_checker.sv
dv/qre_run_checker.sv
dv/tb_quantizing_rle_encoder.sv
